// File: hdl/can_tx_priority_queue_defines.svh
// Assertion macros shared by the CAN transmit queue modules.
// Requires clk_i and rst_ni in the scope of each use.
`ifndef CAN_TX_PRIORITY_QUEUE_DEFINES_SVH
`define CAN_TX_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle property, disabled while reset is asserted.
`define CANQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CANQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/canq_pkg.sv
// Package of the CAN FD transmit queue: sizes, entry and control types, codes,
// and the length to DLC mapping. No dependencies.
`default_nettype none

package canq_pkg;

  localparam int EVENT_DEPTH    = 4;
  localparam int PERIODIC_DEPTH = 8;
  localparam int NUM_BUSES      = 2;

  // A ring of depth N holds N-1 frames; the chains keep exactly that many cells.
  localparam int EV_CAP  = EVENT_DEPTH - 1;
  localparam int PER_CAP = PERIODIC_DEPTH - 1;
  localparam int EV_CW   = $clog2(EVENT_DEPTH);
  localparam int PER_CW  = $clog2(PERIODIC_DEPTH);
  localparam int BUS_W   = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

  localparam int ID_W    = 11;
  localparam int LEN_W   = 8;
  localparam int TAG_W   = 16;
  localparam int DLC_W   = 4;
  localparam int DROP_W  = 16;
  localparam int SLOT_W  = 2;
  localparam int BUSN_W  = 2;
  localparam int KIND_W  = 3;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;
  localparam int M_USED_W  = 1 + ID_W + DLC_W + TAG_W + 1 + DROP_W;
  localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } canq_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    canq_entry_t data;
  } canq_cmd_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic        single;
    logic        hit;
    canq_entry_t head;
  } canq_stat_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_SENT      = 3'd3,
    KIND_DISCARDED = 3'd4,
    KIND_DONE      = 3'd5
  } canq_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN
  } canq_state_e;

  typedef enum logic {
    ACT_SUBMIT  = 1'b0,
    ACT_SERVICE = 1'b1
  } canq_action_e;

  // Returns {legal, dlc}.
  function automatic logic [DLC_W:0] canq_len_to_dlc(input logic [LEN_W-1:0] len);
    logic [DLC_W:0] r;
    if (len <= 8'd8) begin
      r = {1'b1, len[DLC_W-1:0]};
    end else begin
      case (len)
        8'd12:   r = {1'b1, 4'd9};
        8'd16:   r = {1'b1, 4'd10};
        8'd20:   r = {1'b1, 4'd11};
        8'd24:   r = {1'b1, 4'd12};
        8'd32:   r = {1'b1, 4'd13};
        8'd48:   r = {1'b1, 4'd14};
        8'd64:   r = {1'b1, 4'd15};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/canq_cell.sv
// One storage cell of a queue chain: loads a new frame or takes its neighbor's.
// Depends on canq_pkg.
`default_nettype none

module canq_cell (
  input  wire                  clk_i,
  input  wire                  load_i,
  input  canq_pkg::canq_entry_t load_data_i,
  input  wire                  shift_i,
  input  canq_pkg::canq_entry_t shift_data_i,
  output canq_pkg::canq_entry_t data_o
);
  import canq_pkg::*;

  canq_entry_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: hdl/canq_event_queue.sv
// High-priority queue of one bus: a chain of cells, oldest frame in cell 0.
// Depends on canq_pkg, canq_cell and the assertion macro header.
`default_nettype none
`include "can_tx_priority_queue_defines.svh"

module canq_event_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  canq_pkg::canq_cmd_t  cmd_i,
  output canq_pkg::canq_stat_t stat_o
);
  import canq_pkg::*;

  logic [EV_CW-1:0] count_q, count_d;
  logic             full;
  logic [EV_CAP-1:0] load_vec;
  canq_entry_t      cells      [EV_CAP];
  canq_entry_t      shift_data [EV_CAP];

  assign full = (count_q == EV_CW'(EV_CAP));

  for (genvar i = 0; i < EV_CAP; i++) begin : g_cell
    assign load_vec[i] = cmd_i.push && (count_q == EV_CW'(i));
    if (i == EV_CAP - 1) begin : g_end
      assign shift_data[i] = cells[i];
    end else begin : g_mid
      assign shift_data[i] = cells[i+1];
    end
    canq_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (load_vec[i]),
      .load_data_i  (cmd_i.data),
      .shift_i      (cmd_i.pop),
      .shift_data_i (shift_data[i]),
      .data_o       (cells[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + EV_CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - EV_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.empty  = (count_q == '0);
  assign stat_o.full   = full;
  assign stat_o.single = (count_q == EV_CW'(1));
  assign stat_o.hit    = 1'b0;
  assign stat_o.head   = cells[0];

  `CANQ_ASSERT(a_ev_push_room, cmd_i.push |-> !full, "event queue push while full")

endmodule

`default_nettype wire

// File: hdl/canq_periodic_queue.sv
// Periodic queue of one bus: a chain of cells with identifier match so that a
// frame replaces its queued twin. Depends on canq_pkg, canq_cell and the macro header.
`default_nettype none
`include "can_tx_priority_queue_defines.svh"

module canq_periodic_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  canq_pkg::canq_cmd_t  cmd_i,
  output canq_pkg::canq_stat_t stat_o
);
  import canq_pkg::*;

  logic [PER_CW-1:0]  count_q, count_d;
  logic [PER_CAP-1:0] occ, match, load_vec;
  logic               hit;
  canq_entry_t        cells      [PER_CAP];
  canq_entry_t        shift_data [PER_CAP];

  assign hit = |match;

  for (genvar i = 0; i < PER_CAP; i++) begin : g_cell
    assign occ[i]      = (PER_CW'(i) < count_q);
    assign match[i]    = occ[i] && (cells[i].id == cmd_i.data.id);
    // replace the matching frame in place, else append behind the last one
    assign load_vec[i] = cmd_i.push && (hit ? match[i] : (count_q == PER_CW'(i)));
    if (i == PER_CAP - 1) begin : g_end
      assign shift_data[i] = cells[i];
    end else begin : g_mid
      assign shift_data[i] = cells[i+1];
    end
    canq_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (load_vec[i]),
      .load_data_i  (cmd_i.data),
      .shift_i      (cmd_i.pop),
      .shift_data_i (shift_data[i]),
      .data_o       (cells[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push && !hit) begin
      count_d = count_q + PER_CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - PER_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.empty  = (count_q == '0);
  assign stat_o.full   = (count_q == PER_CW'(PER_CAP));
  assign stat_o.single = (count_q == PER_CW'(1));
  assign stat_o.hit    = hit;
  assign stat_o.head   = cells[0];

  `CANQ_ASSERT(a_per_unique_id, $onehot0(match), "periodic queue holds a duplicate identifier")
  `CANQ_ASSERT(a_per_pop_nonempty, cmd_i.pop |-> (count_q != '0), "periodic queue pop while empty")

endmodule

`default_nettype wire

// File: hdl/can_tx_priority_queue.sv
// Top level of the CAN FD transmit queue: input latch, sequencer, drop
// counters and output register. Depends on canq_pkg, both queue modules, macro header.
//
//   channel  | direction | tdata                      | tuser   | tlast
//   s_axis   | in        | frame fields, 48 bits      | action  | -
//   m_axis   | out       | result fields, 56 bits     | kind    | last result of item
//
// An item is taken in ST_IDLE and evaluated in ST_EVAL; ST_DRAIN then gives one
// result per drained frame, and a service tick on a valid bus passes ST_EVAL
// without a result before draining. Drain results come from the single shared
// dequeue path, popping one frame from a queue chain per cycle while output is free.
// Reset clears the queue counts, drop counters and sequencer at once; no sweep.
// A stalled output holds the sequencer; a new item is taken once the sequencer is
// back in idle even while the final result still waits in the output register.
`default_nettype none
`include "can_tx_priority_queue_defines.svh"

module can_tx_priority_queue (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // bus_number[1:0], frame_id[12:2], frame_length[20:13], payload_tag[36:21],
  // event_req[37], extended_flag[38], fd_flag[39], brs_flag[40],
  // free_slots[42:41], zero pad[47:43]
  input  wire [canq_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // action[0]
  input  wire                               s_axis_tuser_i,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // bus_index[0], out_id[11:1], dlc_code[15:12], out_tag[31:16],
  // from_event_queue[32], drop_count[48:33], zero pad[55:49]
  output logic [canq_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // kind[2:0]
  output logic [canq_pkg::KIND_W-1:0]       m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i
);
  import canq_pkg::*;

  // ---------------------------------------------------------------- input latch
  canq_state_e       state_q, state_d;
  canq_action_e      action_q;
  logic              bus_ok_q, hp_q, flags_ok_q;
  logic [BUS_W-1:0]  bus_q;
  canq_entry_t       ent_q;
  logic [SLOT_W-1:0] slots_q, slots_d;

  logic              s_fire;
  logic [BUSN_W-1:0] in_bus;
  logic              in_bus_ok;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_bus          = s_axis_tdata_i[1:0];
  assign in_bus_ok       = (in_bus != '0) && ({1'b0, in_bus} <= 3'(NUM_BUSES));

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      action_q   <= canq_action_e'(s_axis_tuser_i);
      bus_ok_q   <= in_bus_ok;
      bus_q      <= in_bus_ok ? BUS_W'(in_bus - 2'd1) : '0;
      ent_q.id   <= s_axis_tdata_i[12:2];
      ent_q.len  <= s_axis_tdata_i[20:13];
      ent_q.tag  <= s_axis_tdata_i[36:21];
      hp_q       <= s_axis_tdata_i[37];
      // extended identifiers are refused; FD with bit-rate switch is required
      flags_ok_q <= !s_axis_tdata_i[38] && s_axis_tdata_i[39] && s_axis_tdata_i[40];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      slots_q <= s_axis_tdata_i[42:41];
    end else begin
      slots_q <= slots_d;
    end
  end

  // ---------------------------------------------------------------- queues
  canq_cmd_t  ev_cmd   [NUM_BUSES];
  canq_cmd_t  per_cmd  [NUM_BUSES];
  canq_stat_t ev_stat  [NUM_BUSES];
  canq_stat_t per_stat [NUM_BUSES];

  for (genvar gb = 0; gb < NUM_BUSES; gb++) begin : g_bus
    canq_event_queue u_event_queue (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (ev_cmd[gb]),
      .stat_o (ev_stat[gb])
    );
    canq_periodic_queue u_periodic_queue (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (per_cmd[gb]),
      .stat_o (per_stat[gb])
    );
  end

  // ---------------------------------------------------------------- drop counters
  logic [DROP_W-1:0] drop_q [NUM_BUSES];
  logic [DROP_W-1:0] drop_sel, drop_bump;
  logic              drop_inc;

  assign drop_sel  = drop_q[bus_q];
  // saturate at all ones
  assign drop_bump = (&drop_sel) ? drop_sel : drop_sel + DROP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUSES; i++) begin
        drop_q[i] <= '0;
      end
    end else if (drop_inc) begin
      drop_q[bus_q] <= drop_bump;
    end
  end

  // ---------------------------------------------------------------- decode
  canq_stat_t        ev_st, per_st;
  canq_entry_t       head;
  logic              out_free, push_full, take_ev, more_after;
  logic              drain_done, drain_last, legal;
  logic [DLC_W-1:0]  dlc;
  logic [SLOT_W-1:0] slots_after;
  logic              m_valid_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    ev_st       = ev_stat[bus_q];
    per_st      = per_stat[bus_q];
    // an identifier already queued is replaced, so a hit never needs room
    push_full   = hp_q ? ev_st.full : (per_st.full && !per_st.hit);
    take_ev     = !ev_st.empty;
    head        = take_ev ? ev_st.head : per_st.head;
    {legal, dlc} = canq_len_to_dlc(head.len);
    slots_after = legal ? slots_q - SLOT_W'(1) : slots_q;
    more_after  = take_ev ? (!ev_st.single || !per_st.empty) : !per_st.single;
    drain_done  = (slots_q == '0) || (ev_st.empty && per_st.empty);
    drain_last  = (action_q == ACT_SUBMIT) && ((slots_after == '0) || !more_after);
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          if (action_q == ACT_SERVICE) begin
            state_d = bus_ok_q ? ST_DRAIN : ST_IDLE;
          end else if (!bus_ok_q || !flags_ok_q || push_full || (slots_q == '0)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free && (drain_done || drain_last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- outputs
  logic              emit;
  canq_kind_e        r_kind;
  logic              r_bus, r_ev, r_last;
  logic [ID_W-1:0]   r_id;
  logic [DLC_W-1:0]  r_dlc;
  logic [TAG_W-1:0]  r_tag;
  logic [DROP_W-1:0] r_drop;

  always_comb begin
    emit     = 1'b0;
    drop_inc = 1'b0;
    slots_d  = slots_q;
    r_kind   = KIND_DONE;
    r_bus    = bus_q[0];
    r_id     = ent_q.id;
    r_dlc    = '0;
    r_tag    = ent_q.tag;
    r_ev     = 1'b0;
    r_drop   = drop_sel;
    r_last   = 1'b1;
    for (int i = 0; i < NUM_BUSES; i++) begin
      ev_cmd[i]  = '{push: 1'b0, pop: 1'b0, data: ent_q};
      per_cmd[i] = '{push: 1'b0, pop: 1'b0, data: ent_q};
    end
    case (state_q)
      ST_EVAL: begin
        if (out_free) begin
          if (action_q == ACT_SERVICE) begin
            // invalid bus: lone service-done result with everything cleared
            if (!bus_ok_q) begin
              emit   = 1'b1;
              r_kind = KIND_DONE;
              r_bus  = 1'b0;
              r_id   = '0;
              r_tag  = '0;
              r_drop = '0;
            end
          end else if (!bus_ok_q) begin
            emit   = 1'b1;
            r_kind = KIND_REJECTED;
            r_bus  = 1'b0;
            r_drop = '0;
          end else if (!flags_ok_q) begin
            emit   = 1'b1;
            r_kind = KIND_REJECTED;
          end else if (push_full) begin
            emit     = 1'b1;
            drop_inc = 1'b1;
            r_kind   = KIND_FULL;
            r_ev     = hp_q;
            r_drop   = drop_bump;
          end else begin
            emit   = 1'b1;
            r_kind = KIND_ACCEPTED;
            r_ev   = hp_q;
            r_last = (slots_q == '0);
            if (hp_q) begin
              ev_cmd[bus_q].push = 1'b1;
            end else begin
              per_cmd[bus_q].push = 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          if (drain_done) begin
            // close a service tick; a submit never reaches here with nothing left
            emit   = (action_q == ACT_SERVICE);
            r_kind = KIND_DONE;
            r_id   = '0;
            r_tag  = '0;
          end else begin
            emit    = 1'b1;
            slots_d = slots_after;
            r_id    = head.id;
            r_tag   = head.tag;
            r_ev    = take_ev;
            r_last  = drain_last;
            if (take_ev) begin
              ev_cmd[bus_q].pop = 1'b1;
            end else begin
              per_cmd[bus_q].pop = 1'b1;
            end
            if (legal) begin
              r_kind = KIND_SENT;
              r_dlc  = dlc;
            end else begin
              // illegal length: drop and count, no slot used
              r_kind   = KIND_DISCARDED;
              drop_inc = 1'b1;
              r_drop   = drop_bump;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  canq_kind_e        res_kind_q;
  logic              res_bus_q, res_ev_q, res_last_q;
  logic [ID_W-1:0]   res_id_q;
  logic [DLC_W-1:0]  res_dlc_q;
  logic [TAG_W-1:0]  res_tag_q;
  logic [DROP_W-1:0] res_drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_kind_q <= r_kind;
      res_bus_q  <= r_bus;
      res_id_q   <= r_id;
      res_dlc_q  <= r_dlc;
      res_tag_q  <= r_tag;
      res_ev_q   <= r_ev;
      res_drop_q <= r_drop;
      res_last_q <= r_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = res_kind_q;
  assign m_axis_tlast_o  = res_last_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, res_drop_q, res_ev_q, res_tag_q,
                            res_dlc_q, res_id_q, res_bus_q};

  // ---------------------------------------------------------------- checks
  for (genvar ga = 0; ga < NUM_BUSES; ga++) begin : g_chk
    `CANQ_ASSERT_NEXT(a_drop_monotonic, 1'b1, drop_q[ga] >= $past(drop_q[ga]), "drop went down")
  end

  `CANQ_ASSERT(a_drain_valid_bus, (state_q == ST_DRAIN) |-> bus_ok_q, "draining without a valid bus")
  `CANQ_ASSERT(a_done_is_last, (emit && (r_kind == KIND_DONE)) |-> r_last, "service done not last")

endmodule

`default_nettype wire

// File: tb/sv/can_tx_priority_queue_checker.sv
// Checker for the CAN FD transmit queue: watches both stream channels, keeps its
// own copy of the queue state and compares every result transaction.
// Depends on canq_pkg for widths, the entry type and the result kinds.
module can_tx_priority_queue_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire [canq_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  wire                            s_tuser_i,
  input  wire                            s_tvalid_i,
  input  wire                            s_tready_i,
  input  wire [canq_pkg::M_TDATA_W-1:0]  m_tdata_i,
  input  wire [canq_pkg::KIND_W-1:0]     m_tuser_i,
  input  wire                            m_tlast_i,
  input  wire                            m_tvalid_i,
  input  wire                            m_tready_i,
  output int                             mismatch_count_o,
  output int                             outcomes_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import canq_pkg::*;

  typedef struct packed {
    canq_kind_e        kind;
    logic              bus;
    logic [ID_W-1:0]   id;
    logic [DLC_W-1:0]  dlc;
    logic [TAG_W-1:0]  tag;
    logic              from_ev;
    logic [DROP_W-1:0] drops;
    logic              last;
  } tx_outcome_t;

  canq_entry_t       ev_mem  [NUM_BUSES][EVENT_DEPTH];
  canq_entry_t       per_mem [NUM_BUSES][PERIODIC_DEPTH];
  logic [EV_CW-1:0]  ev_rd   [NUM_BUSES];
  logic [EV_CW-1:0]  ev_wr   [NUM_BUSES];
  logic [PER_CW-1:0] per_rd  [NUM_BUSES];
  logic [PER_CW-1:0] per_wr  [NUM_BUSES];
  logic [DROP_W-1:0] drops   [NUM_BUSES];

  tx_outcome_t outcomes_due[$];
  tx_outcome_t step_buf[$];
  int          mismatches = 0;
  int          outcomes_pending = 0;

  assign mismatch_count_o   = mismatches;
  assign outcomes_pending_o = outcomes_pending;

  initial begin
    for (int b = 0; b < NUM_BUSES; b++) begin
      ev_rd[b]  = '0;
      ev_wr[b]  = '0;
      per_rd[b] = '0;
      per_wr[b] = '0;
      drops[b]  = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 200) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [EV_CW-1:0] ev_next(input logic [EV_CW-1:0] p);
    return EV_CW'((int'(p) + 1) % EVENT_DEPTH);
  endfunction

  function automatic logic [PER_CW-1:0] per_next(input logic [PER_CW-1:0] p);
    return PER_CW'((int'(p) + 1) % PERIODIC_DEPTH);
  endfunction

  // DLC for a legal CAN FD length, -1 for any other length.
  function automatic int fd_dlc(input logic [LEN_W-1:0] len);
    if (len <= 8) return int'(len);
    case (len)
      8'd12:   return 9;
      8'd16:   return 10;
      8'd20:   return 11;
      8'd24:   return 12;
      8'd32:   return 13;
      8'd48:   return 14;
      8'd64:   return 15;
      default: return -1;
    endcase
  endfunction

  function automatic void bump_drops(input int b);
    if (drops[b] != '1) drops[b]++;
  endfunction

  function automatic void post(input canq_kind_e kind, input int b, input logic [ID_W-1:0] id,
                               input int dlc, input logic [TAG_W-1:0] tag, input logic ev,
                               input logic [DROP_W-1:0] cnt);
    tx_outcome_t o;
    o.kind    = kind;
    o.bus     = b[0];
    o.id      = id;
    o.dlc     = DLC_W'(dlc);
    o.tag     = tag;
    o.from_ev = ev;
    o.drops   = cnt;
    o.last    = 1'b0;
    step_buf.push_back(o);
  endfunction

  function automatic bit park_event(input int b, input canq_entry_t f);
    if (ev_next(ev_wr[b]) == ev_rd[b]) return 1'b0;
    ev_mem[b][ev_wr[b]] = f;
    ev_wr[b] = ev_next(ev_wr[b]);
    return 1'b1;
  endfunction

  // Replace a queued frame of the same identifier, else append.
  function automatic bit park_periodic(input int b, input canq_entry_t f);
    logic [PER_CW-1:0] c;
    c = per_rd[b];
    while (c != per_wr[b]) begin
      if (per_mem[b][c].id == f.id) begin
        per_mem[b][c] = f;
        return 1'b1;
      end
      c = per_next(c);
    end
    if (per_next(per_wr[b]) == per_rd[b]) return 1'b0;
    per_mem[b][per_wr[b]] = f;
    per_wr[b] = per_next(per_wr[b]);
    return 1'b1;
  endfunction

  function automatic void drain_bus(input int b, input int slots);
    canq_entry_t f;
    logic        ev;
    int          code;
    while (slots > 0) begin
      if (ev_rd[b] != ev_wr[b]) begin
        f = ev_mem[b][ev_rd[b]];
        ev_rd[b] = ev_next(ev_rd[b]);
        ev = 1'b1;
      end else if (per_rd[b] != per_wr[b]) begin
        f = per_mem[b][per_rd[b]];
        per_rd[b] = per_next(per_rd[b]);
        ev = 1'b0;
      end else begin
        break;
      end
      code = fd_dlc(f.len);
      if (code < 0) begin
        // Illegal length: drop it and count, no slot consumed.
        bump_drops(b);
        post(KIND_DISCARDED, b, f.id, 0, f.tag, ev, drops[b]);
      end else begin
        post(KIND_SENT, b, f.id, code, f.tag, ev, drops[b]);
        slots--;
      end
    end
  endfunction

  function automatic void run_tx_queue(input logic [S_TDATA_W-1:0] d, input logic act);
    canq_entry_t f;
    int          bn;
    int          b;
    bit          valid;
    bit          ok;
    logic        hp;
    int          slots;
    tx_outcome_t tail;
    step_buf.delete();
    bn    = int'(d[1:0]);
    f.id  = d[12:2];
    f.len = d[20:13];
    f.tag = d[36:21];
    hp    = d[37];
    slots = int'(d[42:41]);
    valid = (bn >= 1) && (bn <= NUM_BUSES);
    b     = valid ? bn - 1 : 0;
    if (act == ACT_SERVICE) begin
      if (!valid) begin
        post(KIND_DONE, 0, '0, 0, '0, 1'b0, '0);
      end else begin
        drain_bus(b, slots);
        post(KIND_DONE, b, '0, 0, '0, 1'b0, drops[b]);
      end
    end else if (!valid) begin
      post(KIND_REJECTED, 0, f.id, 0, f.tag, 1'b0, '0);
    end else if (d[38] || !d[39] || !d[40]) begin
      post(KIND_REJECTED, b, f.id, 0, f.tag, 1'b0, drops[b]);
    end else begin
      ok = hp ? park_event(b, f) : park_periodic(b, f);
      if (!ok) begin
        bump_drops(b);
        post(KIND_FULL, b, f.id, 0, f.tag, hp, drops[b]);
      end else begin
        post(KIND_ACCEPTED, b, f.id, 0, f.tag, hp, drops[b]);
        drain_bus(b, slots);
      end
    end
    tail = step_buf.pop_back();
    tail.last = 1'b1;
    step_buf.push_back(tail);
    foreach (step_buf[i]) outcomes_due.push_back(step_buf[i]);
  endfunction

  always @(posedge clk_i) begin : watch
    tx_outcome_t got;
    tx_outcome_t want;
    string       d;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got.kind    = canq_kind_e'(m_tuser_i);
        got.bus     = m_tdata_i[0];
        got.id      = m_tdata_i[11:1];
        got.dlc     = m_tdata_i[15:12];
        got.tag     = m_tdata_i[31:16];
        got.from_ev = m_tdata_i[32];
        got.drops   = m_tdata_i[48:33];
        got.last    = m_tlast_i;
        if (outcomes_due.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing due", got.kind));
        end else begin
          want = outcomes_due.pop_front();
          d = "";
          if (got.kind !== want.kind)
            d = {d, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
          if (got.bus !== want.bus)
            d = {d, $sformatf(" bus %0d/%0d", got.bus, want.bus)};
          if (got.id !== want.id)
            d = {d, $sformatf(" id %0h/%0h", got.id, want.id)};
          if (got.dlc !== want.dlc)
            d = {d, $sformatf(" dlc %0d/%0d", got.dlc, want.dlc)};
          if (got.tag !== want.tag)
            d = {d, $sformatf(" tag %0h/%0h", got.tag, want.tag)};
          if (got.from_ev !== want.from_ev)
            d = {d, $sformatf(" event %0b/%0b", got.from_ev, want.from_ev)};
          if (got.drops !== want.drops)
            d = {d, $sformatf(" drops %0d/%0d", got.drops, want.drops)};
          if (got.last !== want.last)
            d = {d, $sformatf(" last %0b/%0b", got.last, want.last)};
          if (d != "") report_mismatch({"got/want", d});
        end
      end
      if (s_tvalid_i && s_tready_i) run_tx_queue(s_tdata_i, s_tuser_i);
      outcomes_pending <= outcomes_due.size();
    end
  end

endmodule

// File: tb/sv/can_tx_priority_queue_test.sv
// Top of the CAN FD transmit queue testbench: clock, reset, stimulus and verdict.
// Depends on canq_pkg, can_tx_priority_queue and can_tx_priority_queue_checker.
module can_tx_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import canq_pkg::*;

  // Frame fields as they sit in s_axis tdata, lowest field last in the list.
  typedef struct packed {
    logic [SLOT_W-1:0] slots;
    logic              brs;
    logic              fd;
    logic              ext;
    logic              hp;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic [ID_W-1:0]   id;
    logic [BUSN_W-1:0] bus;
  } frame_req_t;

  localparam int REQ_W        = $bits(frame_req_t);
  localparam int RANDOM_ITEMS = 205;
  localparam int CALM_ITEMS   = 40;       // last stretch runs with no idling
  localparam int TAIL_CYCLES  = 32;       // extra clocks after the last result, before the verdict
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk_i;
  logic                 rst_ni;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 s_axis_tuser_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [KIND_W-1:0]    m_axis_tuser_o;
  logic                 m_axis_tlast_o;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;

  int mismatches;
  int outcomes_pending;
  int cycles = 0;
  bit calm   = 1'b0;

  can_tx_priority_queue i_dut (.*);

  can_tx_priority_queue_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_tdata_i          (s_axis_tdata_i),
    .s_tuser_i          (s_axis_tuser_i),
    .s_tvalid_i         (s_axis_tvalid_i),
    .s_tready_i         (s_axis_tready_o),
    .m_tdata_i          (m_axis_tdata_o),
    .m_tuser_i          (m_axis_tuser_o),
    .m_tlast_i          (m_axis_tlast_o),
    .m_tvalid_i         (m_axis_tvalid_o),
    .m_tready_i         (m_axis_tready_i),
    .mismatch_count_o   (mismatches),
    .outcomes_pending_o (outcomes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hung handshake: count cycles and give up at the limit.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result sink: stall in random bursts, hold ready high in the calm stretch.
  initial begin
    m_axis_tready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
  end

  // Well-formed FD frame with bit-rate switch and a standard identifier.
  function automatic frame_req_t clean_frame(input logic [BUSN_W-1:0] bus,
                                             input logic [ID_W-1:0] id,
                                             input logic [LEN_W-1:0] len,
                                             input logic [TAG_W-1:0] tag,
                                             input logic hp,
                                             input logic [SLOT_W-1:0] slots);
    frame_req_t r;
    r.bus   = bus;
    r.id    = id;
    r.len   = len;
    r.tag   = tag;
    r.hp    = hp;
    r.ext   = 1'b0;
    r.fd    = 1'b1;
    r.brs   = 1'b1;
    r.slots = slots;
    return r;
  endfunction

  // One of the sixteen legal CAN FD lengths.
  function automatic logic [LEN_W-1:0] pick_fd_length();
    int k;
    k = $urandom_range(0, 15);
    case (k)
      9:       return 8'd12;
      10:      return 8'd16;
      11:      return 8'd20;
      12:      return 8'd24;
      13:      return 8'd32;
      14:      return 8'd48;
      15:      return 8'd64;
      default: return LEN_W'(k);
    endcase
  endfunction

  // Offer one item; maybe idle first. Valid stays high into the next call
  // unless an idle burst or a pause lowers it at a later falling edge.
  task automatic issue(input canq_action_e act, input frame_req_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tuser_i  <= 1'($urandom_range(0, 1));
      s_axis_tdata_i  <= S_TDATA_W'({$urandom, $urandom});
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= S_TDATA_W'(req);
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold the sender until every due result has come out.
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    while (outcomes_pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly well-formed submits on valid buses with a small identifier pool so
  // that replacement and full queues come up; the rest are ticks and noise.
  task automatic random_item(output canq_action_e act, output frame_req_t req);
    int r;
    r   = $urandom_range(0, 99);
    req = REQ_W'({$urandom, $urandom});
    act = ACT_SUBMIT;
    if (r < 18) begin
      act = ACT_SERVICE;
      if ($urandom_range(0, 9) != 0) req.bus = BUSN_W'($urandom_range(1, NUM_BUSES));
    end else if (r < 90) begin
      req.bus = BUSN_W'($urandom_range(1, NUM_BUSES));
      req.ext = 1'b0;
      req.fd  = 1'b1;
      req.brs = 1'b1;
      req.hp  = ($urandom_range(0, 9) < 4);
      if ($urandom_range(0, 9) < 7) req.id = ID_W'($urandom_range(0, 11));
      if ($urandom_range(0, 9) < 8) req.len = pick_fd_length();
      if ($urandom_range(0, 9) < 4) req.slots = '0;
    end
  endtask

  initial begin
    frame_req_t   req;
    canq_action_e act;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Invalid bus numbers on submit and on service tick.
    issue(ACT_SUBMIT, clean_frame(2'd0, 11'd0, 8'd8, 16'h0000, 1'b0, 2'd3));
    issue(ACT_SUBMIT, clean_frame(2'd3, 11'h7ff, 8'd64, 16'hffff, 1'b1, 2'd3));
    issue(ACT_SERVICE, clean_frame(2'd0, 11'h7ff, 8'd0, 16'hffff, 1'b1, 2'd3));
    issue(ACT_SERVICE, clean_frame(2'd3, 11'd0, 8'd0, 16'h0000, 1'b0, 2'd0));

    // Extended identifier, classic format, no bit-rate switch: all rejected.
    req = clean_frame(2'd1, 11'd1, 8'd8, 16'h1111, 1'b0, 2'd3);
    req.ext = 1'b1;
    issue(ACT_SUBMIT, req);
    req = clean_frame(2'd1, 11'd2, 8'd8, 16'h2222, 1'b1, 2'd3);
    req.fd = 1'b0;
    issue(ACT_SUBMIT, req);
    req = clean_frame(2'd1, 11'd3, 8'd8, 16'h3333, 1'b0, 2'd3);
    req.brs = 1'b0;
    issue(ACT_SUBMIT, req);

    // Bus 1: queue without slots, replace by identifier, park illegal lengths,
    // then drain with a tick so discards are skipped without using a slot.
    issue(ACT_SUBMIT, clean_frame(2'd1, 11'd0, 8'd0, 16'h0001, 1'b0, 2'd0));
    issue(ACT_SUBMIT, clean_frame(2'd1, 11'h7ff, 8'd64, 16'hffff, 1'b0, 2'd0));
    issue(ACT_SUBMIT, clean_frame(2'd1, 11'd0, 8'd12, 16'h0002, 1'b0, 2'd0));
    issue(ACT_SUBMIT, clean_frame(2'd1, 11'd5, 8'd255, 16'h0005, 1'b0, 2'd0));
    issue(ACT_SUBMIT, clean_frame(2'd1, 11'd7, 8'd9, 16'h0007, 1'b1, 2'd0));
    issue(ACT_SERVICE, clean_frame(2'd1, 11'd0, 8'd0, 16'h0000, 1'b0, 2'd3));

    // Bus 2: fill the event queue past capacity.
    for (int i = 0; i <= EV_CAP; i++)
      issue(ACT_SUBMIT, clean_frame(2'd2, ID_W'(100 + i), 8'd48, TAG_W'(16'h0a00 + i),
                                    1'b1, 2'd0));
    // Bus 2: fill the periodic queue past capacity, then replace while full;
    // the accepted replacement drains the event frames first.
    for (int i = 0; i <= PER_CAP; i++)
      issue(ACT_SUBMIT, clean_frame(2'd2, ID_W'(200 + i), LEN_W'(i), TAG_W'(16'hb000 + i),
                                    1'b0, 2'd0));
    issue(ACT_SUBMIT, clean_frame(2'd2, 11'd203, 8'd20, 16'hbeef, 1'b0, 2'd3));
    issue(ACT_SERVICE, clean_frame(2'd2, 11'd0, 8'd0, 16'h0000, 1'b0, 2'd3));

    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      random_item(act, req);
      issue(act, req);
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && outcomes_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
